// ===== hdl/mmt_pkg.sv =====
`default_nettype none

package mmt_pkg;

    localparam int IN_W          = 32;
    localparam int ITER_W        = 16;
    localparam int FRAC_BITS_DEF = 28;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_QSUM,
        S_CINIT,
        S_CARD,
        S_TEST,
        S_MUL,
        S_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic sel_z;
        logic q_en;
        logic card_init;
        logic card_step;
        logic upd;
        logic finish;
        logic finish_val;
    } t_cmd;

    typedef struct packed {
        logic card_last;
        logic hit;
        logic escape;
        logic iter_end;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/mmt_ctrl.sv =====
`default_nettype none

module mmt_ctrl
    import mmt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:    n_state = S_QSUM;
            S_QSUM:  n_state = S_CINIT;
            S_CINIT: n_state = S_CARD;
            S_CARD: begin
                if (i_status.card_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.hit) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_UPD;
            S_UPD: begin
                if (i_status.escape || i_status.iter_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_SQ: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.sel_z  = 1'b0;
            end
            S_QSUM: begin
                o_cmd.q_en = 1'b1;
            end
            S_CINIT: begin
                o_cmd.card_init = 1'b1;
            end
            S_CARD: begin
                o_cmd.card_step = 1'b1;
            end
            S_TEST: begin
                if (i_status.hit) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.finish_val = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.sel_z  = 1'b1;
            end
            S_UPD: begin
                priority if (i_status.escape) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.finish_val = 1'b0;
                end else if (i_status.iter_end) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.finish_val = 1'b1;
                end else begin
                    o_cmd.upd = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/mmt_dpath.sv =====
`default_nettype none

module mmt_dpath
    import mmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    input  wire logic signed [IN_W-1:0]   i_c_real,
    input  wire logic signed [IN_W-1:0]   i_c_imag,
    input  wire logic        [ITER_W-1:0] i_max_iter,
    output logic                          o_valid,
    output logic                          o_in_set
);

    localparam int AW   = ((FRAC_BITS + 3 > IN_W) ? FRAC_BITS + 3 : IN_W) + 1;
    localparam int PW   = 2 * AW;
    localparam int SW   = PW + 1;
    localparam int QW   = SW - FRAC_BITS;
    localparam int CW   = 2 * QW + 1;
    localparam int CNTW = $clog2(QW);

    localparam logic signed [AW-1:0] QUARTER  = {{(AW-1){1'b0}}, 1'b1} << (FRAC_BITS - 2);
    localparam logic signed [AW-1:0] ONE      = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [SW-1:0] BULB_LIM = {{(SW-1){1'b0}}, 1'b1} << (2*FRAC_BITS - 4);
    localparam logic signed [SW-1:0] ESC_LIM  = {{(SW-1){1'b0}}, 1'b1} << (2*FRAC_BITS + 2);
    localparam logic [CNTW-1:0]      CNT_LAST = CNTW'(QW - 1);

    logic signed [IN_W-1:0]   r_x;
    logic signed [IN_W-1:0]   r_y;
    logic signed [AW-1:0]     r_zr;
    logic signed [AW-1:0]     r_zi;
    logic        [ITER_W-1:0] r_n;
    logic signed [PW-1:0]     r_p0;
    logic signed [PW-1:0]     r_p1;
    logic signed [PW-1:0]     r_p2;
    logic        [QW-1:0]     r_q;
    logic                     r_bulb;
    logic        [QW-1:0]     r_mq;
    logic signed [CW-1:0]     r_mc;
    logic signed [CW-1:0]     r_acc;
    logic        [CNTW-1:0]   r_cnt;
    logic                     r_valid;
    logic                     r_in_set;

    logic signed [AW-1:0]   x_ext;
    logic signed [AW-1:0]   y_ext;
    logic signed [AW-1:0]   u;
    logic signed [AW-1:0]   v;
    logic signed [AW-1:0]   a0;
    logic signed [AW-1:0]   a1;
    logic signed [AW-1:0]   a2;
    logic signed [AW-1:0]   b2;
    logic signed [PW-1:0]   m0;
    logic signed [PW-1:0]   m1;
    logic signed [PW-1:0]   m2;
    logic signed [SW-1:0]   sum_sq;
    logic signed [SW-1:0]   sum_bulb;
    logic signed [SW-1:0]   diff_sq;
    logic signed [SW-1:0]   q_full;
    logic signed [SW-1:0]   nr_full;
    logic signed [PW-1:0]   ni_full;
    logic signed [AW-1:0]   nr;
    logic signed [AW-1:0]   ni;
    logic signed [QW:0]     w;
    logic signed [PW-1:0]   yy4;
    logic signed [CW-1:0]   yy4_ext;

    assign x_ext = $signed({{(AW-IN_W){r_x[IN_W-1]}}, r_x});
    assign y_ext = $signed({{(AW-IN_W){r_y[IN_W-1]}}, r_y});
    assign u     = x_ext - QUARTER;
    assign v     = x_ext + ONE;

    assign a0 = i_cmd.sel_z ? r_zr : u;
    assign a1 = i_cmd.sel_z ? r_zi : y_ext;
    assign a2 = i_cmd.sel_z ? r_zr : v;
    assign b2 = i_cmd.sel_z ? r_zi : v;

    assign m0 = a0 * a0;
    assign m1 = a1 * a1;
    assign m2 = a2 * b2;

    assign sum_sq   = $signed({r_p0[PW-1], r_p0}) + $signed({r_p1[PW-1], r_p1});
    assign sum_bulb = $signed({r_p2[PW-1], r_p2}) + $signed({r_p1[PW-1], r_p1});
    assign diff_sq  = $signed({r_p0[PW-1], r_p0}) - $signed({r_p1[PW-1], r_p1});
    assign q_full   = sum_sq >>> FRAC_BITS;

    assign nr_full = diff_sq >>> FRAC_BITS;
    assign ni_full = r_p2 >>> (FRAC_BITS - 1);
    assign nr      = $signed(nr_full[AW-1:0]) + x_ext;
    assign ni      = $signed(ni_full[AW-1:0]) + y_ext;

    assign w       = $signed({r_q[QW-1], r_q}) + $signed({{(QW+1-AW){u[AW-1]}}, u});
    assign yy4     = r_p1 >>> 2;
    assign yy4_ext = $signed({{(CW-PW){yy4[PW-1]}}, yy4});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_c_real;
            r_y  <= i_c_imag;
            r_zr <= '0;
            r_zi <= '0;
            r_n  <= '0;
        end else if (i_cmd.upd) begin
            r_zr <= nr;
            r_zi <= ni;
            r_n  <= r_n + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p0 <= m0;
            r_p1 <= m1;
            r_p2 <= m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_en) begin
            r_q    <= q_full[QW-1:0];
            r_bulb <= (sum_bulb < BULB_LIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.card_init) begin
            r_mq  <= r_q;
            r_mc  <= $signed({{(CW-QW-1){w[QW]}}, w});
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.card_step) begin
            if (r_mq[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc  <= r_mc <<< 1;
            r_mq  <= r_mq >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_in_set <= i_cmd.finish_val;
        end
    end

    assign o_status.card_last = (r_cnt == CNT_LAST);
    assign o_status.hit       = r_bulb || (r_acc < yy4_ext);
    assign o_status.escape    = (sum_sq > ESC_LIM);
    assign o_status.iter_end  = (r_n == i_max_iter);

    assign o_valid  = r_valid;
    assign o_in_set = r_in_set;

endmodule

`default_nettype wire

// ===== hdl/mandelbrot_membership_test.sv =====
`default_nettype none

// Sequence: on accept, the squares, their sum, the cardioid set-up and the bit-serial
// cardioid product over QW bits run, where QW = FRAC_BITS + 9 for FRAC_BITS >= 29,
// else 67 - FRAC_BITS (39 at 28); the result follows if a shortcut test hits; otherwise
// a multiply state and an update state repeat until escape or max_iterations updates.
// Throughput: one item at a time; the next is taken in the cycle the result shows.
// Reset: synchronous, active low; clears control state and sets max_iterations to 256.
module mandelbrot_membership_test
    import mmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic signed [IN_W-1:0] i_c_real,
    input  wire logic signed [IN_W-1:0] i_c_imag,
    output logic                        o_valid,
    output logic                        o_in_set,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [ITER_W-1:0]      i_cfg_data
);

    logic [ITER_W-1:0] r_max_iter;
    t_cmd              cmd;
    t_status           status;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_iter <= i_cfg_data;
        end
    end

    mmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mmt_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_c_real   (i_c_real),
        .i_c_imag   (i_c_imag),
        .i_max_iter (r_max_iter),
        .o_valid    (o_valid),
        .o_in_set   (o_in_set)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without work in progress");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("block went idle without a result");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mmt_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int HALF_PERIOD = 4;
    localparam int Q1 = 1 << FRAC;
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC;
    localparam logic signed [127:0] BULB_LIM = 128'sd1 <<< (2 * FRAC - 4);
    localparam logic signed [127:0] ESC_LIM = 128'sd1 <<< (2 * FRAC + 2);
    localparam int PHASE_POINTS = 152;
    localparam int TAIL_CYCLES = 100;

    typedef enum bit {KIND_POINT, KIND_WRITE} t_kind;

    typedef struct {
        t_kind              kind;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [ITER_W-1:0]  limit;
        bit                 drain;
    } t_req;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        bit                 want;
    } t_due;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [IN_W-1:0] i_c_real = '0;
    logic signed [IN_W-1:0] i_c_imag = '0;
    logic o_valid;
    logic o_in_set;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ITER_W-1:0] i_cfg_data = '0;

    t_req pending[$];
    t_due in_set_due[$];
    logic [ITER_W-1:0] iter_limit = MAX_ITER_RST;
    int points_total = 0;
    int points_issued = 0;
    int points_taken = 0;
    int writes_issued = 0;
    int writes_taken = 0;
    bit pt_on_bus = 1'b0;
    bit cfg_on_bus = 1'b0;
    int errors = 0;

    mandelbrot_membership_test #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_c_real(i_c_real),
        .i_c_imag(i_c_imag),
        .o_valid(o_valid),
        .o_in_set(o_in_set),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic bit in_mandelbrot(input logic signed [31:0] c_re,
                                         input logic signed [31:0] c_im,
                                         input logic [ITER_W-1:0] iters);
        logic signed [63:0] x, y, u, v, q, zr, zi, nr, ni;
        logic signed [127:0] yy, acc, lhs;
        int n;
        x = c_re;
        y = c_im;
        yy = y * y;
        u = x - (ONE_Q >>> 2);
        acc = u * u + yy;
        acc = acc >>> FRAC;
        q = acc[63:0];
        v = q + u;
        lhs = q * v;
        if (lhs < (yy >>> 2))
            return 1'b1;
        v = x + ONE_Q;
        acc = v * v + yy;
        if (acc < BULB_LIM)
            return 1'b1;
        zr = '0;
        zi = '0;
        for (n = 0; n < iters; n++) begin
            acc = zr * zr - zi * zi;
            acc = acc >>> FRAC;
            nr = acc[63:0] + x;
            acc = zr * zi;
            acc = acc >>> (FRAC - 1);
            ni = acc[63:0] + y;
            acc = nr * nr + ni * ni;
            if (acc > ESC_LIM)
                return 1'b0;
            zr = nr;
            zi = ni;
        end
        return 1'b1;
    endfunction

    task automatic add_point(input logic signed [31:0] re, input logic signed [31:0] im,
                             input bit drain);
        t_req r;
        r.kind = KIND_POINT;
        r.re = re;
        r.im = im;
        r.limit = '0;
        r.drain = drain;
        pending.push_back(r);
        points_total++;
    endtask

    task automatic add_write(input logic [ITER_W-1:0] limit);
        t_req r;
        r.kind = KIND_WRITE;
        r.re = '0;
        r.im = '0;
        r.limit = limit;
        r.drain = 1'b0;
        pending.push_back(r);
    endtask

    // driver: present items and register writes at the falling edge
    always @(negedge i_clk) begin : drive
        logic nxt_start, nxt_cfg;
        int idle_pct;
        t_req head;
        nxt_start = start;
        nxt_cfg = i_cfg_valid;
        if (i_rst_n && !(pt_on_bus && points_taken != points_issued)
                && !(cfg_on_bus && writes_taken != writes_issued)) begin
            pt_on_bus = 1'b0;
            cfg_on_bus = 1'b0;
            nxt_start = 1'b0;
            nxt_cfg = 1'b0;
            if (points_taken < points_total / 3)
                idle_pct = 6;
            else if (points_taken < 2 * points_total / 3)
                idle_pct = 78;
            else
                idle_pct = 0;
            if (pending.size() != 0) begin
                head = pending[0];
                if (head.kind == KIND_WRITE) begin
                    if (in_set_due.size() == 0) begin
                        void'(pending.pop_front());
                        i_cfg_data <= head.limit;
                        nxt_cfg = 1'b1;
                        cfg_on_bus = 1'b1;
                        writes_issued++;
                    end
                end else if (!(head.drain && in_set_due.size() != 0)
                        && $urandom_range(0, 99) >= idle_pct) begin
                    void'(pending.pop_front());
                    i_c_real <= head.re;
                    i_c_imag <= head.im;
                    nxt_start = 1'b1;
                    pt_on_bus = 1'b1;
                    points_issued++;
                end
            end
        end
        start <= nxt_start;
        i_cfg_valid <= nxt_cfg;
    end

    // monitor: check results, predict accepted items, track register writes
    always @(posedge i_clk) begin : watch
        t_due d;
        if (i_rst_n) begin
            if (o_valid) begin
                if (in_set_due.size() == 0) begin
                    errors++;
                    $display("%0t: in_set result with none expected, got %b",
                             $time, o_in_set);
                end else begin
                    d = in_set_due.pop_front();
                    if (o_in_set !== d.want) begin
                        errors++;
                        $display("%0t: c=(%h,%h) in_set expected %b got %b",
                                 $time, d.re, d.im, d.want, o_in_set);
                    end
                end
            end
            if (start && !busy) begin
                d.re = i_c_real;
                d.im = i_c_imag;
                d.want = in_mandelbrot(i_c_real, i_c_imag, iter_limit);
                in_set_due.push_back(d);
                points_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                iter_limit = i_cfg_data;
                writes_taken++;
            end
        end
    end

    initial begin : stimulus
        logic [ITER_W-1:0] menu [12];
        int p, k, sel;
        logic signed [31:0] re, im;

        menu = '{16'd256, 16'd0, 16'd1, 16'd2, 16'd7, 16'd33,
                 16'd100, 16'd255, 16'd511, 16'd64, 16'd1000,
                 16'd16};

        add_point(0, 0, 1'b0);
        add_point(MAXV, MAXV, 1'b0);
        add_point(MINV, MINV, 1'b0);
        add_point(MAXV, MINV, 1'b0);
        add_point(MINV, MAXV, 1'b0);
        add_point(-Q1, 0, 1'b0);
        add_point(-Q1 / 2 * 3, 0, 1'b0);
        add_point(-2 * Q1, 0, 1'b0);
        add_point(Q1 / 4, 0, 1'b0);
        add_point(Q1 / 4 + Q1 / 100, 0, 1'b0);
        add_point(0, Q1, 1'b0);
        add_point(-Q1 / 4 * 3, Q1 / 10, 1'b0);
        add_point(Q1 / 2, Q1 / 2, 1'b0);
        add_point(-Q1 / 10, Q1 / 100 * 65, 1'b1);
        add_point(32'sh55555555, 32'shAAAAAAAA, 1'b0);
        add_point(0, 2 * Q1, 1'b0);
        add_point(-Q1 / 4 * 5, 0, 1'b0);
        add_point(-Q1 / 4 * 3, 0, 1'b0);
        add_write(16'd0);
        add_point(2 * Q1, 0, 1'b0);
        add_point(-Q1 / 2 * 3, 0, 1'b0);
        add_point(MAXV, MAXV, 1'b0);
        add_write(16'd1);
        add_point(MAXV, 0, 1'b0);
        add_point(Q1, Q1, 1'b0);
        add_write(16'hFFFF);
        add_point(-Q1 / 2 * 3, 0, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(Q1 / 4 + Q1 / 100, 0, 1'b0);
        add_point(MINV, 0, 1'b0);

        for (p = 0; p < 12; p++) begin
            add_write(menu[p]);
            for (k = 0; k < PHASE_POINTS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 25) begin
                    re = $urandom;
                    im = $urandom;
                end else if (sel < 65) begin
                    re = int'($urandom_range(0, 3 * Q1)) - Q1 / 4 * 9;
                    im = int'($urandom_range(0, 3 * Q1)) - Q1 / 2 * 3;
                end else if (sel < 82) begin
                    re = int'($urandom_range(0, Q1 / 50)) - Q1 / 100 * 76;
                    im = int'($urandom_range(0, Q1 / 10 * 3)) - Q1 / 20 * 3;
                end else begin
                    re = int'($urandom_range(0, Q1 / 100 * 6)) + Q1 / 100 * 24;
                    im = int'($urandom_range(0, Q1 / 10)) - Q1 / 20;
                end
                add_point(re, im, $urandom_range(0, 99) == 0);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || pt_on_bus || cfg_on_bus || in_set_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin : watchdog
        #80_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mmt_pkg.sv
hdl/mmt_ctrl.sv
hdl/mmt_dpath.sv
hdl/mandelbrot_membership_test.sv
sim/testbench.sv
